// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked only while out of reset
`define ASSERT_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_ON(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/sabv_pkg.sv =====
// Types, constants and arctangent table for the signed vector angle core
`timescale 1ns / 1ps

package sabv_pkg;

    localparam int XY_W        = 62;
    localparam int Z_W         = 34;
    localparam int ANGLE_W     = 16;
    localparam int ROUND_SHIFT = 17;
    localparam int Q_W         = Z_W - ROUND_SHIFT;
    localparam int PROD_EXT_W  = 64;
    localparam int SCALE_EXP   = 60;
    localparam int TABLE_LEN   = 32;

    localparam logic signed [Z_W-1:0]     HALF_PI_Q30   = 34'sd1686629713;
    localparam logic signed [Z_W-1:0]     ROUND_BIAS    = 34'sd65536;
    localparam logic signed [Q_W-1:0]     ANGLE_LIMIT   = 17'sd25736;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX_OUT = 16'sd25736;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_ZERO_LEN = 1'b1;

    // atan(2^-i) in Q2.30, rounded to nearest
    localparam logic signed [Z_W-1:0] ATAN_Q30 [TABLE_LEN] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128,
        34'sd64,        34'sd32,        34'sd16,        34'sd8,
        34'sd4,         34'sd2,         34'sd1,         34'sd0
    };

    // Per-stage control that travels with the data
    typedef struct packed {
        logic vld;
        logic zero_out;
        logic zero_len;
    } t_ctl;

endpackage

// ===== sv/sabv_rot_stage.sv =====
// One registered CORDIC vectoring micro-rotation
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sabv_rot_stage #(
    parameter int SHIFT = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  sabv_pkg::t_ctl                       i_ctl,
    input  logic signed [sabv_pkg::XY_W-1:0]     i_x,
    input  logic signed [sabv_pkg::XY_W-1:0]     i_y,
    input  logic signed [sabv_pkg::Z_W-1:0]      i_z,
    output sabv_pkg::t_ctl                       o_ctl,
    output logic signed [sabv_pkg::XY_W-1:0]     o_x,
    output logic signed [sabv_pkg::XY_W-1:0]     o_y,
    output logic signed [sabv_pkg::Z_W-1:0]      o_z
);

    localparam logic signed [sabv_pkg::Z_W-1:0] ATAN_K = sabv_pkg::ATAN_Q30[SHIFT];

    sabv_pkg::t_ctl                       r_ctl;
    logic signed [sabv_pkg::XY_W-1:0]     r_x;
    logic signed [sabv_pkg::XY_W-1:0]     r_y;
    logic signed [sabv_pkg::Z_W-1:0]      r_z;
    logic signed [sabv_pkg::XY_W-1:0]     n_x;
    logic signed [sabv_pkg::XY_W-1:0]     n_y;
    logic signed [sabv_pkg::Z_W-1:0]      n_z;
    logic signed [sabv_pkg::XY_W-1:0]     w_xs;
    logic signed [sabv_pkg::XY_W-1:0]     w_ys;

    always_comb begin
        w_xs = i_x >>> SHIFT;
        w_ys = i_y >>> SHIFT;
        if (!i_y[sabv_pkg::XY_W-1]) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN_K;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN_K;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

    `ASSERT_ON(a_hold_x, i_clk, i_rst_n, r_ctl.vld && !i_en |=> $stable(r_x) && $stable(r_z), "stalled stage changed its data")
    `ASSERT_ON(a_hold_vld, i_clk, i_rst_n, r_ctl.vld && !i_en |=> r_ctl.vld, "stalled stage dropped its item")

endmodule

// ===== sv/signed_angle_between_2d_vectors_core.sv =====
// Top level: signed angle atan2(cross, dot) between two 2-D vectors, pipelined CORDIC
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_first_x i_first_y i_second_x i_second_y
//  out     | output    | o_out_valid / i_out_ready  | o_angle o_status
//
// One transfer per cycle on each side while the output is not stalled; the stages are
// multiply, dot/cross sum, half-plane turn, one stage per micro-rotation, and round.
// Each stage loads when it is empty or the stage after it moves, so bubbles close up
// and new items enter while a finished result waits at the output register.
// Reset (synchronous, active low) clears only the valid bits.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module signed_angle_between_2d_vectors_core #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int COMPONENT_WIDTH   = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [COMPONENT_WIDTH-1:0]       i_first_x,
    input  logic signed [COMPONENT_WIDTH-1:0]       i_first_y,
    input  logic signed [COMPONENT_WIDTH-1:0]       i_second_x,
    input  logic signed [COMPONENT_WIDTH-1:0]       i_second_y,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [sabv_pkg::ANGLE_W-1:0]     o_angle,
    output logic                                    o_status
);

    localparam int PROD_W      = 2 * COMPONENT_WIDTH;
    localparam int TOTAL_SHIFT = sabv_pkg::SCALE_EXP - 2 * COMPONENT_WIDTH;
    localparam int UP_SHIFT    = (TOTAL_SHIFT > 0) ? TOTAL_SHIFT : 0;
    localparam int DOWN_SHIFT  = (TOTAL_SHIFT < 0) ? -TOTAL_SHIFT : 0;
    localparam int NROT        = (CORDIC_ITERATIONS < sabv_pkg::TABLE_LEN) ?
                                 CORDIC_ITERATIONS : sabv_pkg::TABLE_LEN;

    // stage 0: products
    sabv_pkg::t_ctl                        r_s0_ctl;
    sabv_pkg::t_ctl                        n_s0_ctl;
    logic signed [PROD_W-1:0]              r_axbx;
    logic signed [PROD_W-1:0]              r_ayby;
    logic signed [PROD_W-1:0]              r_axby;
    logic signed [PROD_W-1:0]              r_aybx;
    logic                                  w_en_s0;

    // stage 1: dot and cross
    sabv_pkg::t_ctl                        r_s1_ctl;
    logic signed [sabv_pkg::XY_W-1:0]      r_s1_x;
    logic signed [sabv_pkg::XY_W-1:0]      r_s1_y;
    logic signed [sabv_pkg::XY_W-1:0]      n_s1_x;
    logic signed [sabv_pkg::XY_W-1:0]      n_s1_y;
    logic signed [sabv_pkg::PROD_EXT_W-1:0] w_e_axbx;
    logic signed [sabv_pkg::PROD_EXT_W-1:0] w_e_ayby;
    logic signed [sabv_pkg::PROD_EXT_W-1:0] w_e_axby;
    logic signed [sabv_pkg::PROD_EXT_W-1:0] w_e_aybx;
    logic                                  w_en_s1;

    // stage 2: half-plane turn
    sabv_pkg::t_ctl                        r_s2_ctl;
    sabv_pkg::t_ctl                        n_s2_ctl;
    logic signed [sabv_pkg::XY_W-1:0]      r_s2_x;
    logic signed [sabv_pkg::XY_W-1:0]      r_s2_y;
    logic signed [sabv_pkg::Z_W-1:0]       r_s2_z;
    logic signed [sabv_pkg::XY_W-1:0]      n_s2_x;
    logic signed [sabv_pkg::XY_W-1:0]      n_s2_y;
    logic signed [sabv_pkg::Z_W-1:0]       n_s2_z;
    logic                                  w_en_s2;

    // rotation chain, element 0 is stage 2
    sabv_pkg::t_ctl                        w_rot_ctl [NROT+1];
    logic signed [sabv_pkg::XY_W-1:0]      w_rot_x   [NROT+1];
    logic signed [sabv_pkg::XY_W-1:0]      w_rot_y   [NROT+1];
    logic signed [sabv_pkg::Z_W-1:0]       w_rot_z   [NROT+1];
    logic                                  w_rot_en  [NROT+1];

    // output stage
    sabv_pkg::t_ctl                        r_out_ctl;
    logic signed [sabv_pkg::ANGLE_W-1:0]   r_angle;
    logic signed [sabv_pkg::ANGLE_W-1:0]   n_angle;
    logic signed [sabv_pkg::Z_W-1:0]       w_zr;
    logic signed [sabv_pkg::Q_W-1:0]       w_q;
    logic                                  w_en_out;

    // load enables, back to front
    assign w_en_out       = !r_out_ctl.vld || i_out_ready;
    assign w_rot_en[NROT] = w_en_out;

    genvar k;
    generate
        for (k = 0; k < NROT; k++) begin : g_rot
            assign w_rot_en[k] = !w_rot_ctl[k+1].vld || w_rot_en[k+1];

            sabv_rot_stage #(
                .SHIFT (k)
            ) u_rot (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_rot_en[k]),
                .i_ctl   (w_rot_ctl[k]),
                .i_x     (w_rot_x[k]),
                .i_y     (w_rot_y[k]),
                .i_z     (w_rot_z[k]),
                .o_ctl   (w_rot_ctl[k+1]),
                .o_x     (w_rot_x[k+1]),
                .o_y     (w_rot_y[k+1]),
                .o_z     (w_rot_z[k+1])
            );
        end
    endgenerate

    assign w_en_s2    = !r_s2_ctl.vld || w_rot_en[0];
    assign w_en_s1    = !r_s1_ctl.vld || w_en_s2;
    assign w_en_s0    = !r_s0_ctl.vld || w_en_s1;
    assign o_in_ready = w_en_s0;

    // stage 0
    always_comb begin
        n_s0_ctl.vld      = i_in_valid;
        n_s0_ctl.zero_out = 1'b0;
        n_s0_ctl.zero_len = ((i_first_x == '0) && (i_first_y == '0)) ||
                            ((i_second_x == '0) && (i_second_y == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl.vld <= 1'b0;
        end else if (w_en_s0) begin
            r_s0_ctl <= n_s0_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_s0) begin
            r_axbx <= i_first_x * i_second_x;
            r_ayby <= i_first_y * i_second_y;
            r_axby <= i_first_x * i_second_y;
            r_aybx <= i_first_y * i_second_x;
        end
    end

    // stage 1: scale to a 2^58 magnitude bound, then sum
    always_comb begin
        w_e_axbx = sabv_pkg::PROD_EXT_W'(r_axbx);
        w_e_ayby = sabv_pkg::PROD_EXT_W'(r_ayby);
        w_e_axby = sabv_pkg::PROD_EXT_W'(r_axby);
        w_e_aybx = sabv_pkg::PROD_EXT_W'(r_aybx);
        n_s1_x = sabv_pkg::XY_W'((w_e_axbx <<< UP_SHIFT) >>> DOWN_SHIFT) +
                 sabv_pkg::XY_W'((w_e_ayby <<< UP_SHIFT) >>> DOWN_SHIFT);
        n_s1_y = sabv_pkg::XY_W'((w_e_axby <<< UP_SHIFT) >>> DOWN_SHIFT) -
                 sabv_pkg::XY_W'((w_e_aybx <<< UP_SHIFT) >>> DOWN_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.vld <= 1'b0;
        end else if (w_en_s1) begin
            r_s1_ctl <= r_s0_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_s1) begin
            r_s1_x <= n_s1_x;
            r_s1_y <= n_s1_y;
        end
    end

    // stage 2: left half plane turned by +-pi/2
    always_comb begin
        n_s2_ctl          = r_s1_ctl;
        n_s2_ctl.zero_out = r_s1_ctl.zero_len || ((r_s1_x == '0) && (r_s1_y == '0));
        n_s2_x = r_s1_x;
        n_s2_y = r_s1_y;
        n_s2_z = '0;
        if (r_s1_x[sabv_pkg::XY_W-1]) begin
            if (!r_s1_y[sabv_pkg::XY_W-1]) begin
                n_s2_x = r_s1_y;
                n_s2_y = -r_s1_x;
                n_s2_z = sabv_pkg::HALF_PI_Q30;
            end else begin
                n_s2_x = -r_s1_y;
                n_s2_y = r_s1_x;
                n_s2_z = -sabv_pkg::HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl.vld <= 1'b0;
        end else if (w_en_s2) begin
            r_s2_ctl <= n_s2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_s2) begin
            r_s2_x <= n_s2_x;
            r_s2_y <= n_s2_y;
            r_s2_z <= n_s2_z;
        end
    end

    assign w_rot_ctl[0] = r_s2_ctl;
    assign w_rot_x[0]   = r_s2_x;
    assign w_rot_y[0]   = r_s2_y;
    assign w_rot_z[0]   = r_s2_z;

    // output stage: round half up to Q3.13, saturate, force zero for degenerate inputs
    always_comb begin
        w_zr = w_rot_z[NROT] + sabv_pkg::ROUND_BIAS;
        w_q  = sabv_pkg::Q_W'(w_zr >>> sabv_pkg::ROUND_SHIFT);
        if (w_rot_ctl[NROT].zero_out) begin
            n_angle = '0;
        end else if (w_q > sabv_pkg::ANGLE_LIMIT) begin
            n_angle = sabv_pkg::ANGLE_W'(sabv_pkg::ANGLE_LIMIT);
        end else if (w_q < -sabv_pkg::ANGLE_LIMIT) begin
            n_angle = sabv_pkg::ANGLE_W'(-sabv_pkg::ANGLE_LIMIT);
        end else begin
            n_angle = sabv_pkg::ANGLE_W'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ctl.vld <= 1'b0;
        end else if (w_en_out) begin
            r_out_ctl <= w_rot_ctl[NROT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_angle <= n_angle;
        end
    end

    assign o_out_valid = r_out_ctl.vld;
    assign o_angle     = r_angle;
    assign o_status    = r_out_ctl.zero_len ? sabv_pkg::STATUS_ZERO_LEN : sabv_pkg::STATUS_OK;

    `ASSERT_ON(a_err_zero, i_clk, i_rst_n, o_out_valid && (o_status == sabv_pkg::STATUS_ZERO_LEN) |-> o_angle == '0, "zero-length result with nonzero angle")
    `ASSERT_ON(a_angle_rng, i_clk, i_rst_n, o_out_valid |-> (o_angle <= sabv_pkg::ANGLE_MAX_OUT) && (o_angle >= -sabv_pkg::ANGLE_MAX_OUT), "angle outside -pi..pi")
    `ASSERT_ON(a_in_lands, i_clk, i_rst_n, i_in_valid && o_in_ready |=> r_s0_ctl.vld, "accepted transfer not captured")
    `ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_out_valid, "output valid right after reset")

endmodule

// ===== dv/sabv_angle_checker.sv =====
// Transfer monitor and angle predictor for the signed vector angle core
`timescale 1ns / 1ps

module sabv_angle_checker #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int COMPONENT_WIDTH   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_first_x,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_first_y,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_second_x,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_second_y,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [sabv_pkg::ANGLE_W-1:0] i_angle,
    input  logic                                i_status,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int     PROD_SHIFT  = 60 - 2 * COMPONENT_WIDTH;
    localparam int     STEP_LIMIT  = 32;
    localparam longint TURN_Q30    = 64'sd1686629713;
    localparam longint ROUND_HALF  = 64'sd65536;
    localparam longint ANGLE_CLAMP = 64'sd25736;

    typedef struct packed {
        logic signed [sabv_pkg::ANGLE_W-1:0] angle;
        logic                                status;
    } t_angle_result;

    t_angle_result pending_angles[$];
    int            fail_count   = 0;
    int            results_seen = 0;

    // atan(2^-k) in Q2.30, rounded to nearest
    function automatic longint arctan_step(int k);
        case (k)
            0:  return 64'sd843314857;
            1:  return 64'sd497837829;
            2:  return 64'sd263043837;
            3:  return 64'sd133525159;
            4:  return 64'sd67021687;
            5:  return 64'sd33543516;
            6:  return 64'sd16775851;
            7:  return 64'sd8388437;
            8:  return 64'sd4194283;
            9:  return 64'sd2097149;
            default: begin
                if (k < 31)
                    return 64'sd1 <<< (30 - k);
                return 64'sd0;
            end
        endcase
    endfunction

    function automatic longint narrow_product(longint p);
        if (PROD_SHIFT >= 0)
            return p <<< PROD_SHIFT;
        return p >>> (-PROD_SHIFT);
    endfunction

    function automatic t_angle_result cordic_angle(
        logic signed [COMPONENT_WIDTH-1:0] ax,
        logic signed [COMPONENT_WIDTH-1:0] ay,
        logic signed [COMPONENT_WIDTH-1:0] bx,
        logic signed [COMPONENT_WIDTH-1:0] by
    );
        longint        ux, uy, vx, vy;
        longint        x, y, z, t, xs, ys, q;
        t_angle_result r;
        int            k;
        ux = ax;
        uy = ay;
        vx = bx;
        vy = by;
        r.status = sabv_pkg::STATUS_OK;
        r.angle  = '0;
        if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0)) begin
            r.status = sabv_pkg::STATUS_ZERO_LEN;
            return r;
        end
        x = narrow_product(ux * vx) + narrow_product(uy * vy);
        y = narrow_product(ux * vy) - narrow_product(uy * vx);
        if (x == 0 && y == 0)
            return r;
        z = 0;
        // left half plane: pre-rotate by a quarter turn
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = TURN_Q30;
            end else begin
                x = -y;
                y = t;
                z = -TURN_Q30;
            end
        end
        for (k = 0; k < CORDIC_ITERATIONS && k < STEP_LIMIT; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_step(k);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_step(k);
            end
        end
        q = (z + ROUND_HALF) >>> 17;
        if (q > ANGLE_CLAMP)
            q = ANGLE_CLAMP;
        if (q < -ANGLE_CLAMP)
            q = -ANGLE_CLAMP;
        r.angle = q[sabv_pkg::ANGLE_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("result %0d: %s mismatch, got %0d expected %0d",
                 results_seen, what, got, want);
        fail_count = fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        t_angle_result want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (pending_angles.size() == 0) begin
                    flag_mismatch("unexpected transfer", i_angle, 0);
                end else begin
                    want = pending_angles.pop_front();
                    if (i_angle !== want.angle)
                        flag_mismatch("angle", i_angle, want.angle);
                    if (i_status !== want.status)
                        flag_mismatch("status", i_status, want.status);
                end
                results_seen = results_seen + 1;
            end
            if (i_in_valid && i_in_ready)
                pending_angles.push_back(cordic_angle(i_first_x, i_first_y,
                                                      i_second_x, i_second_y));
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_angles.size();
    end

endmodule

// ===== dv/tb_signed_angle_between_2d_vectors_core.sv =====
// Testbench top for the signed vector angle core: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_signed_angle_between_2d_vectors_core;

    localparam int ITERATIONS      = 16;
    localparam int COMP_W          = 16;
    localparam int DRAIN_CYCLES    = 2 * (ITERATIONS + 4);
    localparam int RANDOM_PAIRS    = 800;
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic signed [COMP_W-1:0]          i_first_x;
    logic signed [COMP_W-1:0]          i_first_y;
    logic signed [COMP_W-1:0]          i_second_x;
    logic signed [COMP_W-1:0]          i_second_y;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic signed [sabv_pkg::ANGLE_W-1:0] o_angle;
    logic                              o_status;

    int fail_count;
    int pending;
    int pairs_sent    = 0;
    int results_taken = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    signed_angle_between_2d_vectors_core #(
        .CORDIC_ITERATIONS (ITERATIONS),
        .COMPONENT_WIDTH   (COMP_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_angle    (o_angle),
        .o_status   (o_status)
    );

    sabv_angle_checker #(
        .CORDIC_ITERATIONS (ITERATIONS),
        .COMPONENT_WIDTH   (COMP_W)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_first_x   (i_first_x),
        .i_first_y   (i_first_y),
        .i_second_x  (i_second_x),
        .i_second_y  (i_second_y),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_angle     (o_angle),
        .i_status    (o_status),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    task automatic offer_pair(int ax, int ay, int bx, int by);
        int gap;
        if ((pairs_sent / 120) % 3 == 2)
            gap = 0;
        else
            gap = $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_first_x  <= ax[COMP_W-1:0];
        i_first_y  <= ay[COMP_W-1:0];
        i_second_x <= bx[COMP_W-1:0];
        i_second_y <= by[COMP_W-1:0];
        do @(posedge i_clk); while (!o_in_ready);
        pairs_sent = pairs_sent + 1;
    endtask

    function automatic int draw_component();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return $signed($urandom_range(0, 65535)) - 32768;
        if (pick < 8)
            return $signed($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 6))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32766;
            default: return 32767;
        endcase
    endfunction

    // receiver: random stalls, recurring no-stall stretches, and one long hold-off
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (results_taken == HOLD_OFF_AT)
                stall = HOLD_OFF_CYCLES;
            else if ((results_taken / 150) % 3 == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 14);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            results_taken = results_taken + 1;
        end
    end

    initial begin
        #2000000;
        $display("[signed_angle_between_2d_vectors_core] ERROR");
        $finish;
    end

    initial begin
        int ax, ay, bx, by, shape;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_first_x  <= '0;
        i_first_y  <= '0;
        i_second_x <= '0;
        i_second_y <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero-length vectors
        offer_pair(0, 0, 5, -3);
        offer_pair(7, 1, 0, 0);
        offer_pair(0, 0, 0, 0);
        // axes and quadrants, left half plane on both sides of the cut
        offer_pair(1, 0, 1, 0);
        offer_pair(1, 0, 0, 1);
        offer_pair(1, 0, 0, -1);
        offer_pair(1, 0, -1, 0);
        offer_pair(0, 1, 0, -1);
        offer_pair(1, 0, -1, 1);
        offer_pair(1, 0, -1, -1);
        offer_pair(1, 0, -32768, 1);
        offer_pair(1, 0, -32768, -1);
        // full-scale components, then small and mixed pairs
        offer_pair(-32768, -32768, -32768, -32768);
        offer_pair(32767, 32767, -32768, -32768);
        offer_pair(-32768, 0, 32767, 0);
        offer_pair(32767, -32768, -32768, 32767);
        offer_pair(-32768, 32767, 32767, -32768);
        offer_pair(0, -32768, -32768, 0);
        offer_pair(32767, 0, 0, 32767);
        offer_pair(-1, -1, -1, 1);
        offer_pair(1, 1, 32767, 32766);
        offer_pair(12345, -23456, -30000, 17);

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            ax = draw_component();
            ay = draw_component();
            bx = draw_component();
            by = draw_component();
            shape = $urandom_range(0, 39);
            if (shape == 0) begin
                ax = 0;
                ay = 0;
            end else if (shape == 1) begin
                bx = 0;
                by = 0;
            end else if (shape < 4) begin
                bx = -ax;
                by = -ay;
            end else if (shape < 6) begin
                bx = ax;
                by = ay;
            end
            offer_pair(ax, ay, bx, by);
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[signed_angle_between_2d_vectors_core] OK");
        else
            $display("[signed_angle_between_2d_vectors_core] ERROR");
        $finish;
    end

endmodule
